// File: rtl/mfd_pkg.sv
// shared types, constants and helpers of the moveable feast date generator
package mfd_pkg;

    // saturation bounds of the input year
    localparam logic [13:0] YEAR_MIN = 14'd1583;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // holiday codes, also the order of emission
    localparam logic [2:0] HOL_CARNIVAL_START = 3'd0;
    localparam logic [2:0] HOL_CARNIVAL_END   = 3'd1;
    localparam logic [2:0] HOL_GOOD_FRIDAY    = 3'd2;
    localparam logic [2:0] HOL_EASTER         = 3'd3;
    localparam logic [2:0] HOL_ASCENSION      = 3'd4;
    localparam logic [2:0] HOL_WHITSUNTIDE    = 3'd5;

    // month numbers that matter for month lengths
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    // entries between the computus pipeline and the emitter
    localparam int unsigned QUEUE_DEPTH = 2;

    // easter date of one year plus its leap flag
    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic       leap;
    } t_easter;

    // day offset of each holiday from easter sunday
    function automatic logic signed [7:0] feast_offset(input logic [2:0] hol);
        logic signed [7:0] off;
        unique case (hol)
            HOL_CARNIVAL_START: off = -8'sd49;
            HOL_CARNIVAL_END:   off = -8'sd47;
            HOL_GOOD_FRIDAY:    off = -8'sd2;
            HOL_EASTER:         off = 8'sd0;
            HOL_ASCENSION:      off = 8'sd39;
            HOL_WHITSUNTIDE:    off = 8'sd49;
            default:            off = 8'sd0;
        endcase
        return off;
    endfunction

    // gregorian month length
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default:                                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/mfd_year_if.sv
// input channel carrying one year per transfer
interface mfd_year_if;
    logic        valid;
    logic        ready;
    logic [13:0] year;

    modport source (output valid, output year, input ready);
    modport sink   (input valid, input year, output ready);
endinterface

// File: rtl/mfd_feast_if.sv
// output channel carrying one holiday date per transfer
interface mfd_feast_if;
    logic       valid;
    logic       ready;
    logic [2:0] holiday;
    logic [4:0] day_of_month;
    logic [3:0] month_number;
    logic       last;

    modport source (output valid, output holiday, output day_of_month,
                    output month_number, output last, input ready);
    modport sink   (input valid, input holiday, input day_of_month,
                    input month_number, input last, output ready);
endinterface

// File: rtl/mfd_front.sv
// front end: eight stage computus pipeline from year to easter date
module mfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mfd_year_if.sink         i_year_ch,
    output logic             o_push,
    output mfd_pkg::t_easter o_entry,
    input  logic             i_full
);
    import mfd_pkg::*;

    logic       w_en;
    logic [7:0] r_vld;

    // stage 1
    logic [13:0] r1_year;
    // stage 2
    logic [23:0] w_p100;
    logic [25:0] w_p19;
    logic [13:0] r2_year;
    logic [6:0]  r2_q100;
    logic [9:0]  r2_q19;
    // stage 3
    logic [13:0] w_m100, w_r100, w_m19, w_r19;
    logic        w_c_hi;
    logic [6:0]  w_b, w_c;
    logic [4:0]  w_a;
    logic        w_leap;
    logic [4:0]  r3_a;
    logic [6:0]  r3_b, r3_c;
    logic        r3_leap;
    // stage 4
    logic [6:0]  w_fn, w_fr;
    logic [18:0] w_pf;
    logic [2:0]  w_fq, w_f;
    logic [4:0]  r4_a, r4_d, r4_i;
    logic [6:0]  r4_b;
    logic [2:0]  r4_f;
    logic [1:0]  r4_e, r4_k;
    logic        r4_leap;
    // stage 5
    logic [6:0]  w_gn, w_gr;
    logic [22:0] w_pg;
    logic [5:0]  w_gq, w_g;
    logic [8:0]  w_s;
    logic [8:0]  r5_s;
    logic [5:0]  r5_g;
    logic [4:0]  r5_a, r5_i;
    logic [1:0]  r5_e, r5_k;
    logic        r5_leap;
    // stage 6
    logic [8:0]  w_hs, w_hr;
    logic [20:0] w_ph;
    logic [4:0]  w_hq, w_h;
    logic [4:0]  r6_h, r6_a, r6_i;
    logic [1:0]  r6_e, r6_k;
    logic        r6_leap;
    // stage 7
    logic [6:0]  w_ls, w_lr;
    logic [20:0] w_pl;
    logic [3:0]  w_lq;
    logic [2:0]  w_l;
    logic [4:0]  r7_a, r7_h;
    logic [2:0]  r7_l;
    logic        r7_leap;
    // stage 8
    logic [9:0]  w_ms;
    logic        w_m, w_apr;
    logic [7:0]  w_base;
    t_easter     w_ent, r8_ent;

    // whole pipeline stalls only when its last stage cannot drain
    assign w_en            = !(r_vld[7] && i_full);
    assign i_year_ch.ready = w_en;
    assign o_push          = r_vld[7] && !i_full;
    assign o_entry         = r8_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[6:0], i_year_ch.valid};
        end
    end

    // reciprocal quotients, one correction each
    assign w_p100 = 24'(r1_year) * 24'd655;
    assign w_p19  = 26'(r1_year) * 26'd3449;

    assign w_m100 = 14'(r2_q100) * 14'd100;
    assign w_r100 = r2_year - w_m100;
    assign w_c_hi = (w_r100[7:0] >= 8'd100);
    assign w_b    = r2_q100 + 7'(w_c_hi);
    assign w_c    = w_c_hi ? 7'(w_r100[7:0] - 8'd100) : w_r100[6:0];
    assign w_m19  = 14'(r2_q19) * 14'd19;
    assign w_r19  = r2_year - w_m19;
    assign w_a    = (w_r19[5:0] >= 6'd19) ? 5'(w_r19[5:0] - 6'd19) : w_r19[4:0];
    // century years are leap only when the century divides by four
    assign w_leap = (w_c == 7'd0) ? (w_b[1:0] == 2'd0) : (w_c[1:0] == 2'd0);

    assign w_fn = r3_b + 7'd8;
    assign w_pf = 19'(w_fn) * 19'd2621;
    assign w_fq = w_pf[18:16];
    assign w_fr = w_fn - 7'(w_fq) * 7'd25;
    assign w_f  = (w_fr >= 7'd25) ? w_fq + 3'd1 : w_fq;

    assign w_gn = r4_b - 7'(r4_f) + 7'd1;
    assign w_pg = 23'(w_gn) * 23'd21845;
    assign w_gq = w_pg[21:16];
    assign w_gr = w_gn - 7'(w_gq) * 7'd3;
    assign w_g  = (w_gr >= 7'd3) ? w_gq + 6'd1 : w_gq;
    assign w_s  = 9'(r4_a) * 9'd19 + 9'(r4_b) + 9'd15 - 9'(r4_d);

    assign w_hs = r5_s - 9'(r5_g);
    assign w_ph = 21'(w_hs) * 21'd2184;
    assign w_hq = w_ph[20:16];
    assign w_hr = w_hs - 9'(w_hq) * 9'd30;
    assign w_h  = (w_hr >= 9'd30) ? 5'(w_hr - 9'd30) : w_hr[4:0];

    assign w_ls = 7'd32 + 7'({r6_e, 1'b0}) + 7'({r6_i, 1'b0}) - 7'(r6_h) - 7'(r6_k);
    assign w_pl = 21'(w_ls) * 21'd9362;
    assign w_lq = w_pl[19:16];
    assign w_lr = w_ls - 7'(w_lq) * 7'd7;
    assign w_l  = (w_lr >= 7'd7) ? 3'(w_lr - 7'd7) : w_lr[2:0];

    // packed date base lies in 107..149, so march or april only
    assign w_ms   = 10'(r7_a) + 10'(r7_h) * 10'd11 + 10'(r7_l) * 10'd22;
    assign w_m    = (w_ms >= 10'd451);
    assign w_base = 8'd114 + 8'(r7_h) + 8'(r7_l) - (w_m ? 8'd7 : 8'd0);
    assign w_apr  = (w_base >= 8'd124);

    always_comb begin
        w_ent.month = w_apr ? MONTH_APR : MONTH_MAR;
        w_ent.day   = 5'(w_base - (w_apr ? 8'd123 : 8'd92));
        w_ent.leap  = r7_leap;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (i_year_ch.year < YEAR_MIN) begin
                r1_year <= YEAR_MIN;
            end else if (i_year_ch.year > YEAR_MAX) begin
                r1_year <= YEAR_MAX;
            end else begin
                r1_year <= i_year_ch.year;
            end

            r2_year <= r1_year;
            r2_q100 <= w_p100[22:16];
            r2_q19  <= w_p19[25:16];

            r3_a    <= w_a;
            r3_b    <= w_b;
            r3_c    <= w_c;
            r3_leap <= w_leap;

            r4_a    <= r3_a;
            r4_b    <= r3_b;
            r4_d    <= r3_b[6:2];
            r4_e    <= r3_b[1:0];
            r4_i    <= r3_c[6:2];
            r4_k    <= r3_c[1:0];
            r4_f    <= w_f;
            r4_leap <= r3_leap;

            r5_s    <= w_s;
            r5_g    <= w_g;
            r5_a    <= r4_a;
            r5_e    <= r4_e;
            r5_i    <= r4_i;
            r5_k    <= r4_k;
            r5_leap <= r4_leap;

            r6_h    <= w_h;
            r6_a    <= r5_a;
            r6_e    <= r5_e;
            r6_i    <= r5_i;
            r6_k    <= r5_k;
            r6_leap <= r5_leap;

            r7_a    <= r6_a;
            r7_h    <= r6_h;
            r7_l    <= w_l;
            r7_leap <= r6_leap;

            r8_ent  <= w_ent;
        end
    end

endmodule

// File: rtl/mfd_queue.sv
// small register queue of easter dates between front and back end
module mfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mfd_pkg::t_easter i_data,
    output logic             o_full,
    input  logic             i_pop,
    output mfd_pkg::t_easter o_data,
    output logic             o_empty
);
    import mfd_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_easter            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/mfd_back.sv
// back end: walks the six holiday offsets of one easter date, one per cycle while the output is taken
module mfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  mfd_pkg::t_easter i_data,
    output logic             o_pop,
    mfd_feast_if.source      o_feast_ch
);
    import mfd_pkg::*;

    t_easter           r_ent;
    logic              r_busy;
    logic [2:0]        r_idx;
    logic              r_out_valid;
    logic [2:0]        r_hol;
    logic [4:0]        r_day;
    logic [3:0]        r_mon;
    logic              r_last;
    logic              w_load, w_done;
    logic signed [7:0] w_sd;
    logic [3:0]        w_mon;

    assign w_load = r_busy && (!r_out_valid || o_feast_ch.ready);
    assign w_done = w_load && (r_idx == HOL_WHITSUNTIDE);
    assign o_pop  = !i_empty && (!r_busy || w_done);

    // offsets reach at most two month borders either way
    always_comb begin
        w_sd  = $signed({3'b000, r_ent.day}) + feast_offset(r_idx);
        w_mon = r_ent.month;
        for (int j = 0; j < 2; j++) begin
            if (w_sd < 8'sd1) begin
                w_mon = w_mon - 4'd1;
                w_sd  = w_sd + $signed({3'b000, month_len(w_mon, r_ent.leap)});
            end
        end
        for (int j = 0; j < 2; j++) begin
            if (w_sd > $signed({3'b000, month_len(w_mon, r_ent.leap)})) begin
                w_sd  = w_sd - $signed({3'b000, month_len(w_mon, r_ent.leap)});
                w_mon = w_mon + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= HOL_CARNIVAL_START;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_feast_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= HOL_CARNIVAL_START;
            end else if (w_done) begin
                r_busy <= 1'b0;
                r_idx  <= HOL_CARNIVAL_START;
            end else if (w_load) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_data;
        end
        if (w_load) begin
            r_hol  <= r_idx;
            r_day  <= w_sd[4:0];
            r_mon  <= w_mon;
            r_last <= (r_idx == HOL_WHITSUNTIDE);
        end
    end

    assign o_feast_ch.valid        = r_out_valid;
    assign o_feast_ch.holiday      = r_hol;
    assign o_feast_ch.day_of_month = r_day;
    assign o_feast_ch.month_number = r_mon;
    assign o_feast_ch.last         = r_last;

endmodule

// File: rtl/moveable_feast_date_generator.sv
// top level of the moveable feast date generator
// Each year transferred on i_year_ch (clamped to 1583..9999) produces six transfers on
// o_feast_ch, in the order carnival start, carnival end, good friday, easter, ascension and
// whitsuntide, with last set on the sixth. The back end emits one date per cycle while
// o_feast_ch is ready, and that emitter, not the pipeline, sets the sustained rate of years.
// On its way out a year passes, in order, the eight computus stages, the queue write, the
// emitter's working register and its output register. Both ends may stall freely; the queue
// lets new years enter while earlier dates are still being emitted.
module moveable_feast_date_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfd_year_if.sink    i_year_ch,
    mfd_feast_if.source o_feast_ch
);
    import mfd_pkg::*;

    // front to queue
    logic    w_push;
    logic    w_full;
    t_easter w_push_ent;

    // queue to back
    logic    w_pop;
    logic    w_empty;
    t_easter w_pop_ent;

    // computus pipeline: saturates the year and finds easter plus the leap flag
    mfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_year_ch (i_year_ch),
        .o_push    (w_push),
        .o_entry   (w_push_ent),
        .i_full    (w_full)
    );

    // decouples the pipeline from the slower emitter
    mfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_ent),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_ent),
        .o_empty (w_empty)
    );

    // emitter: applies the six offsets with month carry and drives the output register
    mfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_data     (w_pop_ent),
        .o_pop      (w_pop),
        .o_feast_ch (o_feast_ch)
    );

    // last marks whitsuntide and nothing else
    a_last_on_whitsun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_feast_ch.valid |->
            (o_feast_ch.last == (o_feast_ch.holiday == HOL_WHITSUNTIDE)))
        else $error("last flag does not match holiday");

    // within a year the next date follows right after a transfer, holiday counting up
    a_next_holiday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_feast_ch.valid && o_feast_ch.ready && !o_feast_ch.last) |=>
            (o_feast_ch.valid && (o_feast_ch.holiday == 3'($past(o_feast_ch.holiday) + 3'd1))))
        else $error("holiday sequence broken");

    // all feasts fall between february and june
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_feast_ch.valid |->
            (o_feast_ch.month_number >= MONTH_FEB && o_feast_ch.month_number <= MONTH_JUN
             && o_feast_ch.day_of_month != 5'd0))
        else $error("feast date out of range");

    // queue cannot be full and empty together
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("queue full and empty");

endmodule

// File: bench/tb_moveable_feast_date_generator.sv
// self-checking testbench: random and directed years in, six predicted feast dates checked out
`timescale 1ns / 100ps

module tb_moveable_feast_date_generator;
    import mfd_pkg::*;

    // one predicted holiday date, same fields as the output channel
    typedef struct packed {
        logic [2:0] holiday;
        logic [4:0] day;
        logic [3:0] month;
        logic       last;
    } t_feast_date;

    // one year waiting to be sent; drain_first holds it back until all dates are out
    typedef struct {
        logic [13:0] year;
        bit          drain_first;
    } t_year_item;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int MAX_REPORTS    = 10;

    logic i_clk;
    logic i_rst_n;

    mfd_year_if  year_ch ();
    mfd_feast_if feast_ch ();

    moveable_feast_date_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_year_ch  (year_ch),
        .o_feast_ch (feast_ch)
    );

    t_year_item  years_to_send[$];
    t_feast_date feast_dates_due[$];

    int n_years_offered = 0;
    int n_years_taken   = 0;
    int n_dates_seen    = 0;
    int n_errors        = 0;
    int idle_cycles     = 0;

    // emission order of the holidays and their distance from easter sunday
    logic [2:0] feast_order[6] = '{HOL_CARNIVAL_START, HOL_CARNIVAL_END, HOL_GOOD_FRIDAY,
                                   HOL_EASTER, HOL_ASCENSION, HOL_WHITSUNTIDE};
    int         feast_shift[6] = '{-49, -47, -2, 0, 39, 49};

    always #2 i_clk = ~i_clk;

    function automatic int days_in_month(input int mon, input bit leap);
        case (mon)
            MONTH_FEB:                                  return leap ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default:                                    return 31;
        endcase
    endfunction

    // easter by the anonymous gregorian computus, then the six feasts around it
    function automatic void predict_feasts(input logic [13:0] raw_year);
        int          yr;
        int          gold, cent, yoc, c_div4, c_mod4, corr_f, corr_g;
        int          epact, yoc_div4, yoc_mod4, wday_fix, spring_fix, date_code;
        int          paschal_day, paschal_month, day, mon, guard;
        bit          leap;
        t_feast_date fd;

        yr = int'(raw_year);
        if (yr < int'(YEAR_MIN)) yr = int'(YEAR_MIN);
        if (yr > int'(YEAR_MAX)) yr = int'(YEAR_MAX);

        gold       = yr % 19;
        cent       = yr / 100;
        yoc        = yr % 100;
        c_div4     = cent / 4;
        c_mod4     = cent % 4;
        corr_f     = (cent + 8) / 25;
        corr_g     = (cent - corr_f + 1) / 3;
        epact      = (19 * gold + cent - c_div4 - corr_g + 15) % 30;
        yoc_div4   = yoc / 4;
        yoc_mod4   = yoc % 4;
        wday_fix   = (32 + 2 * c_mod4 + 2 * yoc_div4 - epact - yoc_mod4) % 7;
        spring_fix = (gold + 11 * epact + 22 * wday_fix) / 451;
        date_code  = epact + wday_fix - 7 * spring_fix + 114;

        paschal_day   = date_code % 31 + 1;
        paschal_month = date_code / 31;
        leap          = ((yr % 4) == 0) && !(((yr % 100) == 0) && ((yr % 400) != 0));

        for (int k = 0; k < 6; k++) begin
            day = paschal_day + feast_shift[k];
            mon = paschal_month;
            // carry backwards or forwards over month borders
            for (guard = 0; guard < 12 && day < 1; guard++) begin
                mon = mon - 1;
                day = day + days_in_month(mon, leap);
            end
            for (guard = 0; guard < 12 && day > days_in_month(mon, leap); guard++) begin
                day = day - days_in_month(mon, leap);
                mon = mon + 1;
            end
            fd.holiday = feast_order[k];
            fd.day     = day[4:0];
            fd.month   = mon[3:0];
            fd.last    = (feast_order[k] == HOL_WHITSUNTIDE);
            feast_dates_due.push_back(fd);
        end
    endfunction

    // a stretch in the middle of the run where neither side idles
    function automatic bit quiet_window();
        return (n_years_taken >= 45) && (n_years_taken < 75);
    endfunction

    // input driver: a new year is put up only once the previous one has been transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            year_ch.valid <= 1'b0;
        end else if (n_years_offered == n_years_taken) begin
            if (years_to_send.size() == 0) begin
                year_ch.valid <= 1'b0;
            end else if (years_to_send[0].drain_first && feast_dates_due.size() != 0) begin
                // hold off until the block has emptied out
                year_ch.valid <= 1'b0;
            end else if (!quiet_window() && $urandom_range(0, 99) < 11) begin
                year_ch.valid <= 1'b0;
            end else begin
                year_ch.valid <= 1'b1;
                year_ch.year  <= years_to_send[0].year;
                years_to_send.pop_front();
                n_years_offered++;
            end
        end
    end

    // output side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            feast_ch.ready <= 1'b0;
        end else begin
            feast_ch.ready <= quiet_window() || ($urandom_range(0, 99) >= 11);
        end
    end

    // monitor: predicts on each year transfer and checks each date transfer
    always @(posedge i_clk) begin
        t_feast_date exp_fd;
        if (i_rst_n) begin
            if (year_ch.valid && year_ch.ready) begin
                predict_feasts(year_ch.year);
                n_years_taken++;
            end
            if (feast_ch.valid && feast_ch.ready) begin
                n_dates_seen++;
                if (feast_dates_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected date transfer %0d: hol %0d day %0d month %0d",
                                 n_dates_seen, feast_ch.holiday, feast_ch.day_of_month,
                                 feast_ch.month_number);
                end else begin
                    exp_fd = feast_dates_due.pop_front();
                    if (feast_ch.holiday !== exp_fd.holiday
                        || feast_ch.day_of_month !== exp_fd.day
                        || feast_ch.month_number !== exp_fd.month
                        || feast_ch.last !== exp_fd.last) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS) begin
                            $display("mismatch on date transfer %0d", n_dates_seen);
                            $display("  expected hol %0d day %0d month %0d last %0d",
                                     exp_fd.holiday, exp_fd.day, exp_fd.month, exp_fd.last);
                            $display("  got      hol %0d day %0d month %0d last %0d",
                                     feast_ch.holiday, feast_ch.day_of_month,
                                     feast_ch.month_number, feast_ch.last);
                        end
                    end
                end
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((year_ch.valid && year_ch.ready) || (feast_ch.valid && feast_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic queue_year(input logic [13:0] yr, input bit drain_first);
        t_year_item it;
        it.year        = yr;
        it.drain_first = drain_first;
        years_to_send.push_back(it);
    endtask

    initial begin
        int total_years;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        year_ch.valid  = 1'b0;
        year_ch.year   = '0;
        feast_ch.ready = 1'b0;

        // directed: range ends and saturation, leap rule corners, easter on its
        // earliest and latest dates, the two epact corrections, bit patterns
        queue_year(14'd1583, 1'b0);
        queue_year(14'd9999, 1'b0);
        queue_year(14'd0, 1'b0);
        queue_year(14'd16383, 1'b0);
        queue_year(14'd1582, 1'b0);
        queue_year(14'd10000, 1'b0);
        queue_year(14'd2000, 1'b0);
        queue_year(14'd1900, 1'b0);
        queue_year(14'd2100, 1'b0);
        queue_year(14'd2400, 1'b0);
        queue_year(14'd1818, 1'b0);
        queue_year(14'd2285, 1'b0);
        queue_year(14'd1943, 1'b0);
        queue_year(14'd2038, 1'b0);
        queue_year(14'd1954, 1'b0);
        queue_year(14'd1981, 1'b0);
        queue_year(14'd2008, 1'b0);
        queue_year(14'd2024, 1'b0);
        queue_year(14'd2025, 1'b0);
        queue_year(14'd8192, 1'b0);
        queue_year(14'd5461, 1'b0);
        queue_year(14'd10922, 1'b0);
        queue_year(14'd4095, 1'b0);

        // random: mostly in range, some anywhere in the 14 bit field
        for (int i = 0; i < 77; i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_year(14'($urandom_range(0, 16383)), i == 0 || i == 60);
            else
                queue_year(14'($urandom_range(1583, 9999)), i == 0 || i == 60);
        end
        total_years = years_to_send.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_years_taken < total_years || feast_dates_due.size() != 0)
            @(posedge i_clk);
        // let any stray dates show up
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (feast_dates_due.size() != 0)
            n_errors++;
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/mfd_pkg.sv
rtl/mfd_year_if.sv
rtl/mfd_feast_if.sv
rtl/mfd_front.sv
rtl/mfd_queue.sv
rtl/mfd_back.sv
rtl/moveable_feast_date_generator.sv
bench/tb_moveable_feast_date_generator.sv
